/* rtl/midi_clocked_step_sequencer_unit_defines.svh */
// Assertion macros for the step sequencer unit.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef MIDI_CLOCKED_STEP_SEQUENCER_UNIT_DEFINES_SVH
`define MIDI_CLOCKED_STEP_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define MSQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msq_pkg.sv */
// Shared types, constants and helpers of the step sequencer unit.
// No dependencies.
`default_nettype none
package msq_pkg;

  localparam int PATTERNS_DEF = 64;
  localparam int STEPS_DEF    = 64;
  localparam int VOICES_DEF   = 4;
  localparam int TRACKS_DEF   = 4;

  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_IW-1:0] CFG_LOOP = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_CHAN = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_VOFF = 2'd2;

  localparam logic [6:0]  LOOP_RESET = 7'd16;
  localparam logic [15:0] CHAN_RESET = 16'h2108;
  localparam logic [31:0] VOFF_RESET = 32'h7070_7070;

  localparam logic [7:0] TIE_MARK     = 8'hFE;
  localparam logic [7:0] NO_NOTE      = 8'hFF;
  localparam logic [7:0] STAT_OFF     = 8'h80;
  localparam logic [7:0] STAT_ON      = 8'h90;
  localparam logic [7:0] VOFF_NEUTRAL = 8'h70;
  localparam logic [6:0] VEL_MAX      = 7'h7F;
  localparam logic [6:0] VEL_RESET    = 7'd80;

  typedef enum logic [2:0] {
    OP_CLOCK, OP_START, OP_CONT, OP_STOP, OP_NOTE, OP_VEL, OP_LEN, OP_QUEUE
  } op_e;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
  } msg_t;

  typedef struct packed {
    logic row_re;
    logic row_we;
    logic len_re;
    logic len_we;
  } mem_ctl_t;

  typedef struct packed {
    logic emit;
    logic flush;
  } emit_ctl_t;

  function automatic logic [6:0] velo_adj(input logic [6:0] v, input logic [7:0] off);
    logic [8:0] r;
    logic [7:0] d;
    r = 9'd1;
    d = 8'd0;
    if (off > VOFF_NEUTRAL) begin
      r = {2'b00, v} + {1'b0, off - VOFF_NEUTRAL};
    end else begin
      d = VOFF_NEUTRAL - off;
      if (d < {1'b0, v}) begin
        r = {1'b0, {1'b0, v} - d};
      end
    end
    velo_adj = (r > {2'b00, VEL_MAX}) ? VEL_MAX : r[6:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/msq_store.sv */
// Pattern row memory (notes of all voices plus step velocity) and pattern length memory.
// Depends on msq_pkg.
`default_nettype none
module msq_store #(
  parameter int PATTERNS = msq_pkg::PATTERNS_DEF,
  parameter int STEPS    = msq_pkg::STEPS_DEF,
  parameter int VOICES   = msq_pkg::VOICES_DEF,
  localparam int ROWS = PATTERNS * STEPS,
  localparam int AW   = $clog2(ROWS),
  localparam int PW   = $clog2(PATTERNS),
  localparam int LW   = $clog2(STEPS + 1),
  localparam int RW   = VOICES * 8 + 7
) (
  input  wire                    clk_i,
  input  wire msq_pkg::mem_ctl_t ctl_i,
  input  wire [AW-1:0]           row_addr_i,
  input  wire [RW-1:0]           row_wdata_i,
  output logic [RW-1:0]          row_rdata_o,
  input  wire [PW-1:0]           len_addr_i,
  input  wire [LW-1:0]           len_wdata_i,
  output logic [LW-1:0]          len_rdata_o
);

  logic [RW-1:0] row_mem [ROWS];
  logic [LW-1:0] len_mem [PATTERNS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.row_we) begin
      row_mem[row_addr_i] <= row_wdata_i;
    end
    if (ctl_i.row_re) begin
      row_rdata_o <= row_mem[row_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.len_we) begin
      len_mem[len_addr_i] <= len_wdata_i;
    end
    if (ctl_i.len_re) begin
      len_rdata_o <= len_mem[len_addr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/msq_emit.sv */
// Result staging: holds the newest message until the next one or the end of the item,
// so the final one can be marked, and drives the output register. Depends on msq_pkg.
`default_nettype none
`include "midi_clocked_step_sequencer_unit_defines.svh"
module msq_emit (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire msq_pkg::emit_ctl_t ctl_i,
  input  wire msq_pkg::msg_t      msg_i,
  output logic                    en_o,
  output logic                    m_tvalid_o,
  input  wire                     m_tready_i,
  output msq_pkg::msg_t           m_msg_o,
  output logic                    m_tlast_o
);

  logic                      hv_q, hv_d;
  msq_pkg::msg_t             hmsg_q, hmsg_d;
  logic [msq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      ov_q, ov_d;
  msq_pkg::msg_t             omsg_q, omsg_d;
  logic                      olast_q, olast_d;
  logic                      room;

  assign en_o       = !ov_q || m_tready_i;
  assign m_tvalid_o = ov_q;
  assign m_msg_o    = omsg_q;
  assign m_tlast_o  = olast_q;
  assign room       = cnt_q < msq_pkg::CNT_W'(msq_pkg::MAX_RESULTS);

  always_comb begin
    hv_d    = hv_q;
    hmsg_d  = hmsg_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !m_tready_i;
    omsg_d  = omsg_q;
    olast_d = olast_q;
    if (ctl_i.emit && room) begin
      if (hv_q) begin
        ov_d    = 1'b1;
        omsg_d  = hmsg_q;
        olast_d = 1'b0;
      end
      hv_d   = 1'b1;
      hmsg_d = msg_i;
      cnt_d  = cnt_q + msq_pkg::CNT_W'(1);
    end else if (ctl_i.flush) begin
      if (hv_q) begin
        ov_d    = 1'b1;
        omsg_d  = hmsg_q;
        olast_d = 1'b1;
      end
      hv_d  = 1'b0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      hv_q  <= hv_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hmsg_q  <= hmsg_d;
    omsg_q  <= omsg_d;
    olast_q <= olast_d;
  end

  `MSQ_ASSERT_IMP(a_emit_flush_apart, ctl_i.emit, !ctl_i.flush, "emit and flush together")
  `MSQ_ASSERT_IMP(a_act_when_free, ctl_i.emit || ctl_i.flush, en_o, "push while output blocked")
  `MSQ_ASSERT_NXT(a_flush_marks_last, ctl_i.flush && hv_q, m_tvalid_o && m_tlast_o,
                  "held message not released as last")
  `MSQ_ASSERT_NXT(a_emit_pushes_held, ctl_i.emit && hv_q && room, m_tvalid_o && !m_tlast_o,
                  "held message not released on new emit")

endmodule
`default_nettype wire

/* rtl/msq_ctrl.sv */
// Sequencer control: op decode, tick/master/track state, note-off and note-on walks
// over the pattern memories, memory clearing pass. Depends on msq_pkg.
`default_nettype none
module msq_ctrl #(
  parameter int PATTERNS = msq_pkg::PATTERNS_DEF,
  parameter int STEPS    = msq_pkg::STEPS_DEF,
  parameter int VOICES   = msq_pkg::VOICES_DEF,
  parameter int TRACKS   = msq_pkg::TRACKS_DEF,
  localparam int ROWS = PATTERNS * STEPS,
  localparam int AW   = $clog2(ROWS),
  localparam int PW   = $clog2(PATTERNS),
  localparam int SW   = $clog2(STEPS),
  localparam int LW   = $clog2(STEPS + 1),
  localparam int RW   = VOICES * 8 + 7
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [2:0]                    op_i,
  input  wire [5:0]                    pat_i,
  input  wire [5:0]                    stp_i,
  input  wire [1:0]                    voi_i,
  input  wire [1:0]                    trk_i,
  input  wire [7:0]                    dat_i,
  input  wire                          cfg_we_i,
  input  wire [msq_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  wire [msq_pkg::CFG_DW-1:0]    cfg_data_i,
  input  wire                          en_i,
  output msq_pkg::emit_ctl_t           emit_o,
  output msq_pkg::msg_t                msg_o,
  output msq_pkg::mem_ctl_t            mem_o,
  output logic [AW-1:0]                row_addr_o,
  output logic [RW-1:0]                row_wdata_o,
  input  wire [RW-1:0]                 row_rdata_i,
  output logic [PW-1:0]                len_addr_o,
  output logic [LW-1:0]                len_wdata_o,
  input  wire [LW-1:0]                 len_rdata_i
);

  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [2:0] TICK_OFF  = 3'd5;
  localparam logic [2:0] TICK_STEP = 3'd6;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WR_RD, ST_WR, ST_OFF_RD, ST_OFF_LEN, ST_OFF_ROW, ST_OFFS,
    ST_STEP, ST_SW, ST_PL_RD, ST_PL_LEN, ST_PL_ROW, ST_ONS, ST_DONE
  } st_e;

  typedef enum logic [1:0] {PH_OFF, PH_SWAP, PH_STOP} ph_e;

  function automatic logic [AW-1:0] row_of(input int p, input int s);
    row_of = AW'(p * STEPS + s);
  endfunction

  function automatic logic [LW-1:0] len_init(input int i);
    int l;
    l = (i == 0 || i == 2) ? 64 : ((i == 3) ? 12 : 16);
    if (l > STEPS) begin
      l = STEPS;
    end
    len_init = LW'(l);
  endfunction

  st_e st_q, st_d;
  ph_e ph_q;

  logic [6:0]  mll_q;
  logic [15:0] tc_q;
  logic [31:0] vo_q;

  logic [AW-1:0] clr_q;
  logic [TW-1:0] t_q;
  logic [VW-1:0] v_q;
  logic          adv_q;
  logic [2:0]    tick_q;
  logic          run_q;
  logic [6:0]    mst_q;

  logic [PW-1:0] tpat_q  [TRACKS];
  logic [SW-1:0] tstep_q [TRACKS];
  logic          trst_q  [TRACKS];
  logic          qv_q    [TRACKS];
  logic [PW-1:0] qp_q    [TRACKS];
  logic          snv_q   [TRACKS][VOICES];
  logic [6:0]    snn_q   [TRACKS][VOICES];

  msq_pkg::op_e op_q;
  logic [5:0]   pat_q, stp_q;
  logic [1:0]   voi_q;
  logic [7:0]   dat_q;

  logic          fire;
  msq_pkg::op_e  op_in;
  logic          pat_ok, stp_ok, voi_ok, trk_ok;
  logic [2:0]    tick_n;
  logic [6:0]    mst_n;
  logic          t_last, v_last;
  logic [TW-1:0] t_next;
  logic [1:0]    t2;
  logic [3:0]    chan;
  logic [7:0]    voff;
  logic [SW:0]   step_inc;
  logic [SW-1:0] nxt_step, pl_step;
  logic [7:0]    v0_note, cur_note;
  logic [6:0]    row_vel, vel_clamp;
  logic [LW-1:0] len_clamp;
  logic          v0_tie;

  assign op_in      = msq_pkg::op_e'(op_i);
  assign in_ready_o = (st_q == ST_IDLE) && en_i;
  assign fire       = in_valid_i && in_ready_o;
  assign pat_ok     = 32'(pat_i) < PATTERNS;
  assign stp_ok     = 32'(stp_i) < STEPS;
  assign voi_ok     = 32'(voi_i) < VOICES;
  assign trk_ok     = 32'(trk_i) < TRACKS;
  assign tick_n     = tick_q + 3'd1;
  assign mst_n      = mst_q + 7'd1;
  assign t_last     = t_q == TW'(TRACKS - 1);
  assign v_last     = v_q == VW'(VOICES - 1);
  assign t_next     = t_last ? '0 : t_q + TW'(1);
  assign t2         = 2'(t_q);
  assign chan       = tc_q[4*t2 +: 4];
  assign voff       = vo_q[8*t2 +: 8];
  assign step_inc   = {1'b0, tstep_q[t_q]} + (SW+1)'(1);
  assign nxt_step   = (32'(step_inc) >= 32'(len_rdata_i)) ? '0 : step_inc[SW-1:0];
  assign pl_step    = !adv_q ? tstep_q[t_q] : (trst_q[t_q] ? '0 : nxt_step);
  assign v0_note    = row_rdata_i[7:0];
  assign v0_tie     = v0_note == msq_pkg::TIE_MARK;
  assign cur_note   = row_rdata_i[8*v_q +: 8];
  assign row_vel    = row_rdata_i[RW-1 -: 7];
  assign vel_clamp  = (dat_q == 8'd0) ? 7'd1 :
                      ((dat_q > {1'b0, msq_pkg::VEL_MAX}) ? msq_pkg::VEL_MAX : dat_q[6:0]);
  assign len_clamp  = (dat_i == 8'd0) ? LW'(1) :
                      ((32'(dat_i) > STEPS) ? LW'(STEPS) : LW'(dat_i));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mll_q <= msq_pkg::LOOP_RESET;
      tc_q  <= msq_pkg::CHAN_RESET;
      vo_q  <= msq_pkg::VOFF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msq_pkg::CFG_LOOP: mll_q <= cfg_data_i[6:0];
        msq_pkg::CFG_CHAN: tc_q  <= cfg_data_i[15:0];
        msq_pkg::CFG_VOFF: vo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    if (en_i) begin
      unique case (st_q)
        ST_CLEAR: if (clr_q == AW'(ROWS - 1)) st_d = ST_IDLE;
        ST_IDLE: begin
          if (fire) begin
            case (op_in)
              msq_pkg::OP_CLOCK: begin
                if (run_q && tick_n == TICK_OFF) st_d = ST_OFF_RD;
                else if (run_q && tick_n == TICK_STEP) st_d = ST_STEP;
              end
              msq_pkg::OP_START: st_d = ST_PL_RD;
              msq_pkg::OP_CONT: if (tick_n == TICK_STEP) st_d = ST_STEP;
              msq_pkg::OP_STOP: st_d = ST_OFFS;
              msq_pkg::OP_NOTE: if (pat_ok && stp_ok && voi_ok) st_d = ST_WR_RD;
              msq_pkg::OP_VEL: if (pat_ok && stp_ok) st_d = ST_WR_RD;
              default: ;
            endcase
          end
        end
        ST_WR_RD:   st_d = ST_WR;
        ST_WR:      st_d = ST_IDLE;
        ST_OFF_RD:  st_d = ST_OFF_LEN;
        ST_OFF_LEN: st_d = ST_OFF_ROW;
        ST_OFF_ROW: begin
          if (!v0_tie) st_d = ST_OFFS;
          else if (t_last) st_d = ST_DONE;
          else st_d = ST_OFF_RD;
        end
        ST_OFFS: begin
          if (v_last) begin
            unique case (ph_q)
              PH_OFF:  st_d = t_last ? ST_DONE : ST_OFF_RD;
              PH_SWAP: st_d = t_last ? ST_PL_RD : ST_SW;
              PH_STOP: st_d = t_last ? ST_DONE : ST_OFFS;
              default: st_d = ST_DONE;
            endcase
          end
        end
        ST_STEP: st_d = (mst_n == mll_q) ? ST_SW : ST_PL_RD;
        ST_SW: begin
          if (qv_q[t_q]) st_d = ST_OFFS;
          else if (t_last) st_d = ST_PL_RD;
        end
        ST_PL_RD:  st_d = ST_PL_LEN;
        ST_PL_LEN: st_d = ST_PL_ROW;
        ST_PL_ROW: begin
          if (!v0_tie) st_d = ST_ONS;
          else if (t_last) st_d = ST_DONE;
          else st_d = ST_PL_RD;
        end
        ST_ONS: if (v_last) st_d = t_last ? ST_DONE : ST_PL_RD;
        ST_DONE: st_d = ST_IDLE;
        default: st_d = ST_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    mem_o       = '0;
    emit_o      = '0;
    msg_o       = '0;
    row_addr_o  = row_of(int'(tpat_q[t_q]), int'(pl_step));
    row_wdata_o = row_rdata_i;
    len_addr_o  = tpat_q[t_q];
    len_wdata_o = len_clamp;
    if (en_i) begin
      unique case (st_q)
        ST_CLEAR: begin
          mem_o.row_we = 1'b1;
          row_addr_o   = clr_q;
          row_wdata_o  = {msq_pkg::VEL_RESET, {VOICES{msq_pkg::NO_NOTE}}};
          mem_o.len_we = 32'(clr_q) < PATTERNS;
          len_addr_o   = PW'(clr_q);
          len_wdata_o  = len_init(int'(clr_q));
        end
        ST_IDLE: begin
          mem_o.len_we = fire && op_in == msq_pkg::OP_LEN && pat_ok;
          len_addr_o   = PW'(pat_i);
        end
        ST_WR_RD: begin
          mem_o.row_re = 1'b1;
          row_addr_o   = row_of(int'(pat_q), int'(stp_q));
        end
        ST_WR: begin
          mem_o.row_we = 1'b1;
          row_addr_o   = row_of(int'(pat_q), int'(stp_q));
          if (op_q == msq_pkg::OP_NOTE) row_wdata_o[8*voi_q +: 8] = dat_q;
          else row_wdata_o[RW-1 -: 7] = vel_clamp;
        end
        ST_OFF_RD, ST_PL_RD: mem_o.len_re = 1'b1;
        ST_OFF_LEN: begin
          mem_o.row_re = 1'b1;
          row_addr_o   = row_of(int'(tpat_q[t_q]), int'(nxt_step));
        end
        ST_PL_LEN: mem_o.row_re = 1'b1;
        ST_OFFS: begin
          emit_o.emit  = snv_q[t_q][v_q];
          msg_o.status = msq_pkg::STAT_OFF | {4'h0, chan};
          msg_o.note   = snn_q[t_q][v_q];
          msg_o.vel    = 7'd0;
        end
        ST_ONS: begin
          emit_o.emit  = !cur_note[7];
          msg_o.status = msq_pkg::STAT_ON | {4'h0, chan};
          msg_o.note   = cur_note[6:0];
          msg_o.vel    = msq_pkg::velo_adj(row_vel, voff);
        end
        ST_DONE: emit_o.flush = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_OFF;
      clr_q  <= '0;
      t_q    <= '0;
      v_q    <= '0;
      adv_q  <= 1'b0;
      tick_q <= '0;
      run_q  <= 1'b0;
      mst_q  <= '0;
      for (int i = 0; i < TRACKS; i++) begin
        tpat_q[i]  <= PW'(i % PATTERNS);
        tstep_q[i] <= '0;
        trst_q[i]  <= 1'b0;
        qv_q[i]    <= 1'b0;
        for (int j = 0; j < VOICES; j++) begin
          snv_q[i][j] <= 1'b0;
        end
      end
    end else if (en_i) begin
      unique case (st_q)
        ST_CLEAR: clr_q <= clr_q + AW'(1);
        ST_IDLE: begin
          if (fire) begin
            t_q <= '0;
            v_q <= '0;
            case (op_in)
              msq_pkg::OP_CLOCK: begin
                if (run_q) begin
                  tick_q <= (tick_n == TICK_STEP) ? '0 : tick_n;
                  adv_q  <= 1'b1;
                  ph_q   <= PH_OFF;
                end
              end
              msq_pkg::OP_START: begin
                tick_q <= '0;
                run_q  <= 1'b1;
                mst_q  <= '0;
                adv_q  <= 1'b0;
                for (int i = 0; i < TRACKS; i++) begin
                  tstep_q[i] <= '0;
                  trst_q[i]  <= 1'b0;
                end
              end
              msq_pkg::OP_CONT: begin
                run_q  <= 1'b1;
                tick_q <= (tick_n == TICK_STEP) ? '0 : tick_n;
                adv_q  <= 1'b1;
              end
              msq_pkg::OP_STOP: begin
                run_q <= 1'b0;
                ph_q  <= PH_STOP;
              end
              msq_pkg::OP_QUEUE: if (trk_ok && pat_ok) qv_q[TW'(trk_i)] <= 1'b1;
              default: ;
            endcase
          end
        end
        ST_OFF_ROW, ST_PL_ROW: begin
          if (v0_tie) t_q <= t_next;
          else v_q <= '0;
        end
        ST_OFFS, ST_ONS: begin
          if (st_q == ST_ONS && !cur_note[7]) snv_q[t_q][v_q] <= 1'b1;
          v_q <= v_last ? '0 : v_q + VW'(1);
          if (v_last) t_q <= t_next;
        end
        ST_STEP: begin
          mst_q <= (mst_n == mll_q) ? '0 : mst_n;
          ph_q  <= PH_SWAP;
          t_q   <= '0;
        end
        ST_SW: begin
          if (qv_q[t_q]) begin
            tpat_q[t_q] <= qp_q[t_q];
            trst_q[t_q] <= 1'b1;
            qv_q[t_q]   <= 1'b0;
            v_q         <= '0;
          end else begin
            t_q <= t_next;
          end
        end
        ST_PL_LEN: begin
          if (adv_q) begin
            tstep_q[t_q] <= pl_step;
            trst_q[t_q]  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (fire) begin
        op_q  <= op_in;
        pat_q <= pat_i;
        stp_q <= stp_i;
        voi_q <= voi_i;
        dat_q <= dat_i;
        if (op_in == msq_pkg::OP_QUEUE && trk_ok && pat_ok) qp_q[TW'(trk_i)] <= PW'(pat_i);
      end
      if (st_q == ST_ONS && !cur_note[7]) snn_q[t_q][v_q] <= cur_note[6:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/midi_clocked_step_sequencer_unit.sv */
// Top level of the MIDI clocked step sequencer unit.
// Depends on msq_pkg, msq_store, msq_emit and msq_ctrl.
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | tvalid/tready           | tuser op, tdata indices and data
//  m_axis   | out | tvalid/tready           | tdata MIDI message, tlast final one
//  cfg      | in  | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// After reset a clearing pass fills the pattern memory, one row per cycle.
// Every op, from ticks that neither release nor step, length and queue writes, note and
// velocity writes and stop to note-off phases, starts and steps, runs to its end before
// the next input is accepted. A step at the loop boundary also visits every track and the
// voices of each swapped track; tied tracks skip their voices.
// A stalled output register freezes the sequencer; results carry their own staging.
`default_nettype none
module midi_clocked_step_sequencer_unit #(
  parameter int PATTERNS = msq_pkg::PATTERNS_DEF,
  parameter int STEPS    = msq_pkg::STEPS_DEF,
  parameter int VOICES   = msq_pkg::VOICES_DEF,
  parameter int TRACKS   = msq_pkg::TRACKS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // pattern_index[5:0], step_index[11:6], voice_index[13:12], track_index[15:14],
  // data_value[23:16]
  input  wire [23:0]  s_axis_tdata,
  // op[2:0]
  input  wire [2:0]   s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // midi_status[7:0], midi_note[14:8], midi_velocity[21:15], zero[23:22]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  wire         cfg_we_i,
  input  wire [msq_pkg::CFG_IW-1:0] cfg_idx_i,
  input  wire [msq_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int AW = $clog2(PATTERNS * STEPS);
  localparam int PW = $clog2(PATTERNS);
  localparam int LW = $clog2(STEPS + 1);
  localparam int RW = VOICES * 8 + 7;

  msq_pkg::mem_ctl_t  mem_ctl;
  msq_pkg::emit_ctl_t emit_ctl;
  msq_pkg::msg_t      msg, out_msg;
  logic               en;
  logic [AW-1:0]      row_addr;
  logic [RW-1:0]      row_wdata, row_rdata;
  logic [PW-1:0]      len_addr;
  logic [LW-1:0]      len_wdata, len_rdata;

  assign m_axis_tdata = {2'b00, out_msg.vel, out_msg.note, out_msg.status};

  msq_ctrl #(
    .PATTERNS(PATTERNS), .STEPS(STEPS), .VOICES(VOICES), .TRACKS(TRACKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .pat_i       (s_axis_tdata[5:0]),
    .stp_i       (s_axis_tdata[11:6]),
    .voi_i       (s_axis_tdata[13:12]),
    .trk_i       (s_axis_tdata[15:14]),
    .dat_i       (s_axis_tdata[23:16]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .en_i        (en),
    .emit_o      (emit_ctl),
    .msg_o       (msg),
    .mem_o       (mem_ctl),
    .row_addr_o  (row_addr),
    .row_wdata_o (row_wdata),
    .row_rdata_i (row_rdata),
    .len_addr_o  (len_addr),
    .len_wdata_o (len_wdata),
    .len_rdata_i (len_rdata)
  );

  msq_store #(
    .PATTERNS(PATTERNS), .STEPS(STEPS), .VOICES(VOICES)
  ) u_store (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .row_addr_i  (row_addr),
    .row_wdata_i (row_wdata),
    .row_rdata_o (row_rdata),
    .len_addr_i  (len_addr),
    .len_wdata_i (len_wdata),
    .len_rdata_o (len_rdata)
  );

  msq_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (emit_ctl),
    .msg_i      (msg),
    .en_o       (en),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_msg_o    (out_msg),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire
